[rtl/mmp_pkg.sv]
// Shared types, codes and lookup functions for the MIDI message parser.
// No dependencies; imported by midi_message_parser_top.
`default_nettype none

package mmp_pkg;

  localparam int LEN_W   = 2;
  localparam int KIND_W  = 5;
  localparam int CHAN_W  = 5;
  localparam int DATA_W  = 7;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_COMMON  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_TIME      = 2'd3;

  localparam logic [7:0] STATUS_SYSTEM    = 8'hF0;
  localparam logic [7:0] STATUS_REAL_TIME = 8'hF8;
  localparam logic [DATA_W-1:0] CTRL_MODE_FIRST = 7'd120;

  // message kinds
  localparam logic [KIND_W-1:0] KIND_CONTROL_CHANGE = 5'd3;
  localparam logic [KIND_W-1:0] KIND_MODE_BASE      = 5'd7;
  localparam logic [KIND_W-1:0] KIND_SYSEX          = 5'd15;
  localparam logic [KIND_W-1:0] KIND_TIME_CODE      = 5'd16;
  localparam logic [KIND_W-1:0] KIND_SONG_POSITION  = 5'd17;
  localparam logic [KIND_W-1:0] KIND_SONG_SELECT    = 5'd18;
  localparam logic [KIND_W-1:0] KIND_TUNE_REQUEST   = 5'd19;
  localparam logic [KIND_W-1:0] KIND_SYSEX_END      = 5'd20;
  localparam logic [KIND_W-1:0] KIND_CLOCK          = 5'd21;
  localparam logic [KIND_W-1:0] KIND_START          = 5'd22;
  localparam logic [KIND_W-1:0] KIND_CONTINUE       = 5'd23;
  localparam logic [KIND_W-1:0] KIND_STOP           = 5'd24;
  localparam logic [KIND_W-1:0] KIND_ACTIVE_SENSE   = 5'd25;
  localparam logic [KIND_W-1:0] KIND_RESET          = 5'd26;
  localparam logic [KIND_W-1:0] KIND_NONE           = 5'd31;
  localparam logic [KIND_W-1:0] KIND_LAST           = KIND_RESET;

  typedef struct packed {
    logic [CHAN_W-1:0] listen_channel;
    logic              channel_mode_enable;
    logic              system_common_enable;
    logic              real_time_enable;
  } mmp_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [7:0]        status;
    logic [CHAN_W-1:0] chan;
    logic [DATA_W-1:0] d0;
    logic [DATA_W-1:0] d1;
  } mmp_result_t;

  // number of data bytes that follow a status byte 80-F7
  function automatic logic [LEN_W-1:0] msg_len(input logic [7:0] status);
    logic [LEN_W-1:0] len;
    len = 2'd2;
    if (status[6:4] != 3'b111) begin
      unique case (status[6:4])
        3'b100, 3'b101: len = 2'd1;
        default:        len = 2'd2;
      endcase
    end else begin
      unique case (status[3:0])
        4'h0, 4'h1, 4'h3: len = 2'd1;
        4'h2:             len = 2'd2;
        default:          len = 2'd0;
      endcase
    end
    return len;
  endfunction

  function automatic logic [KIND_W-1:0] sys_kind(input logic [3:0] nib);
    logic [KIND_W-1:0] k;
    k = KIND_NONE;
    unique case (nib)
      4'h0:    k = KIND_SYSEX;
      4'h1:    k = KIND_TIME_CODE;
      4'h2:    k = KIND_SONG_POSITION;
      4'h3:    k = KIND_SONG_SELECT;
      4'h6:    k = KIND_TUNE_REQUEST;
      4'h7:    k = KIND_SYSEX_END;
      4'h8:    k = KIND_CLOCK;
      4'hA:    k = KIND_START;
      4'hB:    k = KIND_CONTINUE;
      4'hC:    k = KIND_STOP;
      4'hE:    k = KIND_ACTIVE_SENSE;
      4'hF:    k = KIND_RESET;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // filter and classify a completed message
  function automatic mmp_result_t classify(input logic [7:0] status,
                                           input logic [DATA_W-1:0] d0,
                                           input logic [DATA_W-1:0] d1,
                                           input mmp_cfg_t cfg);
    mmp_result_t r;
    r.hit    = 1'b1;
    r.status = status;
    r.chan   = {1'b0, status[3:0]} + 5'd1;
    r.d0     = d0;
    r.d1     = d1;
    r.kind   = KIND_NONE;
    if (status < STATUS_SYSTEM) begin
      if (cfg.listen_channel != '0 && cfg.listen_channel != r.chan) r.hit = 1'b0;
      r.kind = {2'b00, status[6:4]};
      if (r.kind == KIND_CONTROL_CHANGE && d0 >= CTRL_MODE_FIRST) begin
        if (!cfg.channel_mode_enable) r.hit = 1'b0;
        r.kind = KIND_MODE_BASE + {2'b00, d0[2:0]};
      end
    end else begin
      r.kind = sys_kind(status[3:0]);
      if (r.kind == KIND_NONE) r.hit = 1'b0;
      else if (status >= STATUS_REAL_TIME) begin
        if (!cfg.real_time_enable) r.hit = 1'b0;
      end else if (!cfg.system_common_enable) begin
        r.hit = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/midi_message_parser_top.sv]
// MIDI byte parser with running status: top level, single module.
// Depends on mmp_pkg for codes, lookup tables and the result struct.
// A completed result is registered into the output register, or into the skid entry while the sink stalls.
// Throughput: one byte per cycle while rx_stall is low; the parser state updates in a single register stage.
// A two-entry output buffer (output register plus skid) keeps bytes flowing while
// the sink stalls; rx_stall rises only when both entries hold results.
// Reset clears parser state, empties the buffer and loads register defaults.
`default_nettype none

module midi_message_parser_top
  import mmp_pkg::*;
#(
  parameter int DATA_BYTES_MAX = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 rx_valid,
  output logic                      rx_stall,
  input  wire logic [7:0]           rx_byte,
  output logic                      msg_valid,
  input  wire logic                 msg_stall,
  output logic [KIND_W-1:0]         kind,
  output logic [7:0]                status_byte,
  output logic [CHAN_W-1:0]         channel_number,
  output logic [DATA_W-1:0]         data_first,
  output logic [DATA_W-1:0]         data_second
);

  localparam int FW = $clog2(DATA_BYTES_MAX + 1);
  localparam int IW = $clog2(DATA_BYTES_MAX);

  mmp_cfg_t cfg;

  logic [7:0]       pending_status, pending_status_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0] bytes_expected, bytes_expected_next;
  logic [FW-1:0]    fill_position, fill_position_next;
  logic [DATA_W-1:0] data_store [DATA_BYTES_MAX];

  logic        accept;
  logic        store_we;
  logic [DATA_W-1:0] d0_view, d1_view;
  mmp_result_t res;

  logic        skid_valid;
  mmp_result_t out_reg, skid_reg;

  assign accept   = rx_valid && !rx_stall;
  assign rx_stall = skid_valid;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_channel       <= '0;
      cfg.channel_mode_enable  <= 1'b1;
      cfg.system_common_enable <= 1'b1;
      cfg.real_time_enable     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LISTEN_CHANNEL: cfg.listen_channel       <= cfg_data;
        CFG_CHANNEL_MODE:   cfg.channel_mode_enable  <= cfg_data[0];
        CFG_SYSTEM_COMMON:  cfg.system_common_enable <= cfg_data[0];
        CFG_REAL_TIME:      cfg.real_time_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // parser step
  always_comb begin
    pending_status_next  = pending_status;
    bytes_remaining_next = bytes_remaining;
    bytes_expected_next  = bytes_expected;
    fill_position_next   = fill_position;
    store_we = 1'b0;
    d0_view  = data_store[0];
    d1_view  = data_store[1];
    res      = classify(pending_status, d0_view, d1_view, cfg);
    res.hit  = 1'b0;
    if (accept) begin
      priority if (rx_byte >= STATUS_REAL_TIME) begin
        // real-time beat leaves the message in progress alone
        res = classify(rx_byte, d0_view, d1_view, cfg);
      end else if (rx_byte[7]) begin
        pending_status_next  = rx_byte;
        bytes_expected_next  = msg_len(rx_byte);
        bytes_remaining_next = msg_len(rx_byte);
        fill_position_next   = '0;
        if (msg_len(rx_byte) == '0) res = classify(rx_byte, d0_view, d1_view, cfg);
      end else if (bytes_remaining != '0 && fill_position < FW'(DATA_BYTES_MAX)) begin
        store_we = 1'b1;
        if (fill_position[IW-1:0] == IW'(0)) d0_view = rx_byte[DATA_W-1:0];
        if (fill_position[IW-1:0] == IW'(1)) d1_view = rx_byte[DATA_W-1:0];
        fill_position_next   = fill_position + FW'(1);
        bytes_remaining_next = bytes_remaining - LEN_W'(1);
        if (bytes_remaining == LEN_W'(1)) begin
          res = classify(pending_status, d0_view, d1_view, cfg);
          fill_position_next   = '0;
          bytes_remaining_next = bytes_expected;
        end
      end else begin
        // stray data byte: dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_status  <= '0;
      bytes_remaining <= '0;
      bytes_expected  <= '0;
      fill_position   <= '0;
    end else begin
      pending_status  <= pending_status_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_expected  <= bytes_expected_next;
      fill_position   <= fill_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DATA_BYTES_MAX; i++) data_store[i] <= '0;
    end else if (store_we) begin
      data_store[fill_position[IW-1:0]] <= rx_byte[DATA_W-1:0];
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!msg_valid || !msg_stall) begin
      if (skid_valid) begin
        msg_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        msg_valid <= res.hit;
      end
    end else if (res.hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!msg_valid || !msg_stall) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (res.hit) begin
      skid_reg <= res;
    end
  end

  assign kind           = out_reg.kind;
  assign status_byte    = out_reg.status;
  assign channel_number = out_reg.chan;
  assign data_first     = out_reg.d0;
  assign data_second    = out_reg.d1;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> msg_valid) else $error("skid entry full while output empty");

  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= bytes_expected) else $error("remaining count above expected");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_position <= FW'(DATA_BYTES_MAX)) else $error("fill position past store");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> kind <= KIND_LAST) else $error("result kind out of range");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_stall |=> msg_valid && $stable(kind) && $stable(status_byte))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
